// ===== rtl/core/ground_drift_median_ema_macros.svh =====
// Assertion macros shared by the checker files of the drift estimator.
// Depends on a clock named clk and a synchronous reset named rst in the using scope.
`ifndef GROUND_DRIFT_MEDIAN_EMA_MACROS_SVH
`define GROUND_DRIFT_MEDIAN_EMA_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GDM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/gdm_pkg.sv =====
// Shared types and constants of the ground drift median/EMA estimator.
// No dependencies; used by the interface users, the selection unit and the top level.
`default_nettype none

package gdm_pkg;

  localparam int HEIGHT_W      = 16;
  localparam int AVG_W         = 24;
  localparam int CORR_W        = 19;
  localparam int CFG_DATA_W    = 10;
  localparam int CFG_IDX_W     = 2;
  localparam int MAX_CELLS_DEF = 2048;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EMA_WEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 2'd3;

  // Reset values of the registers.
  localparam logic       ENABLE_RST     = 1'b1;
  localparam logic [8:0] EMA_WEIGHT_RST = 9'd26;
  localparam logic [9:0] DEAD_BAND_RST  = 10'd50;
  localparam logic [9:0] STEP_LIMIT_RST = 10'd5;

  // Full weight, 256/256.
  localparam logic [8:0] WEIGHT_FULL = 9'd256;

  // Flips a two's complement height to offset binary and back.
  localparam logic [HEIGHT_W-1:0] SIGN_BIT = 16'h8000;

  typedef struct packed {
    logic signed [HEIGHT_W-1:0] cell_height;
    logic                       cell_valid;
    logic                       height_finite;
    logic                       last_cell;
  } gdm_cell_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] correction;
    logic signed [AVG_W-1:0]  drift_estimate;
    logic                     apply_correction;
    logic                     window_empty;
  } gdm_result_t;

  // Status from the selection unit to the top level.
  typedef struct packed {
    logic                       done;
    logic                       empty;
    logic signed [HEIGHT_W-1:0] median;
  } gdm_sel_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/gdm_stream_if.sv =====
// Valid/ready stream channel carrying one payload struct per request.
// Payload type is a parameter; the users take their structs from gdm_pkg.
`default_nettype none

interface gdm_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/gdm_select.sv =====
// Height store and median selection unit: one memory, one read port, and a
// bit-at-a-time radix search that rescans the kept heights once per result bit.
// Depends on gdm_pkg.
`default_nettype none

module gdm_select #(
  parameter int MAX_CELLS = gdm_pkg::MAX_CELLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [gdm_pkg::HEIGHT_W-1:0]    wr_height,
  input  logic                            start,
  output gdm_pkg::gdm_sel_status_t        status
);
  import gdm_pkg::*;

  localparam int ADDR_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int CNT_W  = $clog2(MAX_CELLS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CELLS);

  // Heights are held in offset binary so that unsigned order is signed order.
  logic [HEIGHT_W-1:0] mem [MAX_CELLS];

  logic [CNT_W-1:0]    count;
  logic                scanning;
  logic [CNT_W-1:0]    rd_addr;
  logic                rd_pend;
  logic [HEIGHT_W-1:0] rd_data;
  logic [HEIGHT_W-1:0] prefix;
  logic [HEIGHT_W-1:0] hi_mask;
  logic [HEIGHT_W-1:0] bit_sel;
  logic [CNT_W-1:0]    rank;
  logic [CNT_W-1:0]    less;
  logic                done;
  logic                empty;
  logic [HEIGHT_W-1:0] median;

  logic                store_ok;
  logic                hit;
  logic                pass_end;
  logic                take_one;
  logic [HEIGHT_W-1:0] prefix_next;

  assign store_ok = wr_en && (count < CNT_MAX);

  // Element matches the decided upper bits and has a zero at the bit under test.
  assign hit = rd_pend && (((rd_data ^ prefix) & hi_mask) == '0) &&
               ((rd_data & bit_sel) == '0);
  assign pass_end    = scanning && (rd_addr == count) && !rd_pend;
  assign take_one    = !(rank < less);
  assign prefix_next = take_one ? (prefix | bit_sel) : prefix;

  always_ff @(posedge clk) begin
    if (store_ok) begin
      mem[count[ADDR_W-1:0]] <= wr_height ^ SIGN_BIT;
    end
    rd_data <= mem[rd_addr[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      scanning <= 1'b0;
      rd_pend  <= 1'b0;
      done     <= 1'b0;
    end else begin
      done    <= 1'b0;
      rd_pend <= 1'b0;
      if (store_ok) begin
        count <= count + 1'b1;
      end
      if (start) begin
        if (count == '0) begin
          done   <= 1'b1;
          empty  <= 1'b1;
          median <= '0;
        end else begin
          scanning <= 1'b1;
          rank     <= count >> 1;
          prefix   <= '0;
          hi_mask  <= '0;
          bit_sel  <= SIGN_BIT;
          rd_addr  <= '0;
          less     <= '0;
        end
      end else if (scanning) begin
        // Issue the next read; its data lands in the following cycle.
        if (rd_addr != count) begin
          rd_addr <= rd_addr + 1'b1;
          rd_pend <= 1'b1;
        end
        if (hit) begin
          less <= less + 1'b1;
        end
        if (pass_end) begin
          prefix  <= prefix_next;
          if (take_one) begin
            rank <= rank - less;
          end
          less    <= '0;
          rd_addr <= '0;
          hi_mask <= hi_mask | bit_sel;
          bit_sel <= bit_sel >> 1;
          if (bit_sel[0]) begin
            scanning <= 1'b0;
            done     <= 1'b1;
            empty    <= 1'b0;
            median   <= prefix_next ^ SIGN_BIT;
            count    <= '0;
          end
        end
      end
      // An empty frame still ends here.
      if (start && (count == '0)) begin
        count <= '0;
      end
    end
  end

  assign status.done   = done;
  assign status.empty  = empty;
  assign status.median = median;

endmodule

`default_nettype wire

// ===== rtl/core/ground_drift_median_ema.sv =====
// Ground drift estimator: median of a window of map heights, smoothed by an EMA.
// Depends on gdm_pkg, gdm_stream_if and gdm_select.
// Usage:
//  - cells (sink): one request per window cell {cell_height, cell_valid,
//    height_finite, last_cell}. Cells that are valid and finite are kept,
//    up to MAX_CELLS per frame; later ones are dropped.
//  - results (source): one request per frame, after the cell flagged last_cell:
//    {correction, drift_estimate, apply_correction, window_empty}.
//  - cfg_we/cfg_index/cfg_data: register writes, taken at any edge with cfg_we
//    high; write only while no frame is in flight.
// Flow:
//  - Cells that do not end a frame stream back to back.
//  - At a frame end the median is found one bit per pass, and each pass reads
//    every kept height once through the single read port of the height store;
//    the multiplier is skipped on the first frame or when disabled.
//  - cells.ready is low during reset and from the last cell until the result is loaded.
// Stall: the result sits in an output register until taken; cells of the next
//  frame are accepted meanwhile, and a finished frame waits before loading.
// Reset: average and start flag clear, registers return to their defaults,
//  the store fill count clears; no clearing pass is needed.
`default_nettype none

module ground_drift_median_ema #(
  parameter int MAX_CELLS = gdm_pkg::MAX_CELLS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [gdm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gdm_pkg::CFG_DATA_W-1:0]     cfg_data,
  gdm_stream_if.sink                         cells,
  gdm_stream_if.source                       results
);
  import gdm_pkg::*;

  localparam logic [2:0] ST_COLLECT = 3'd0;
  localparam logic [2:0] ST_SELECT  = 3'd1;
  localparam logic [2:0] ST_MUL_NEW = 3'd2;
  localparam logic [2:0] ST_MUL_OLD = 3'd3;
  localparam logic [2:0] ST_SUM     = 3'd4;
  localparam logic [2:0] ST_CORR    = 3'd5;

  logic [2:0] state;

  // Configuration registers.
  logic       enable;
  logic [8:0] ema_weight;
  logic [9:0] dead_band_mm;
  logic [9:0] step_limit_mm;

  // Datapath state.
  logic signed [AVG_W-1:0] avg;
  logic                    started;
  logic signed [AVG_W-1:0] meas;
  logic                    empty_flag;
  logic signed [33:0]      prod;
  logic signed [33:0]      acc;
  logic                    sel_start;

  gdm_result_t res;
  logic        res_valid;

  gdm_sel_status_t sel_status;

  logic cell_req;
  logic keep;

  assign cells.ready = (state == ST_COLLECT) && !rst;
  assign cell_req    = cells.valid && cells.ready;
  assign keep        = cell_req && cells.payload.cell_valid && cells.payload.height_finite;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= ENABLE_RST;
      ema_weight    <= EMA_WEIGHT_RST;
      dead_band_mm  <= DEAD_BAND_RST;
      step_limit_mm <= STEP_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:     enable        <= cfg_data[0];
        CFG_EMA_WEIGHT: ema_weight    <= cfg_data[8:0];
        CFG_DEAD_BAND:  dead_band_mm  <= cfg_data[9:0];
        CFG_STEP_LIMIT: step_limit_mm <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  gdm_select #(
    .MAX_CELLS (MAX_CELLS)
  ) u_select (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (keep),
    .wr_height (cells.payload.cell_height),
    .start     (sel_start),
    .status    (sel_status)
  );

  // Shared multiplier: weight times new value, then remaining weight times average.
  logic [8:0]         w_sat;
  logic [8:0]         w_rest;
  logic signed [9:0]  mul_coef;
  logic signed [AVG_W-1:0] mul_opnd;
  logic signed [33:0] mul_out;
  logic signed [34:0] sum_full;
  logic signed [AVG_W-1:0] avg_new;

  assign w_sat    = (ema_weight > WEIGHT_FULL) ? WEIGHT_FULL : ema_weight;
  assign w_rest   = WEIGHT_FULL - w_sat;
  assign mul_coef = (state == ST_MUL_NEW) ? signed'({1'b0, w_sat}) : signed'({1'b0, w_rest});
  assign mul_opnd = (state == ST_MUL_NEW) ? meas : avg;
  assign mul_out  = mul_coef * mul_opnd;
  assign sum_full = acc + prod;
  // Floor divide by 256: arithmetic shift, keep the low 24 bits.
  assign avg_new  = sum_full[AVG_W+7:8];

  // Dead band check and clamp.
  logic [AVG_W-1:0]  avg_mag;
  logic [17:0]       band;
  logic [17:0]       lim;
  logic              over_band;
  logic [17:0]       step_mag;
  logic [CORR_W-1:0] corr_val;

  assign avg_mag   = avg[AVG_W-1] ? AVG_W'(-avg) : avg;
  assign band      = {dead_band_mm, 8'd0};
  assign lim       = {step_limit_mm, 8'd0};
  assign over_band = enable && (avg_mag > AVG_W'(band));
  assign step_mag  = (avg_mag < AVG_W'(lim)) ? avg_mag[17:0] : lim;
  assign corr_val  = avg[AVG_W-1] ? (CORR_W'(0) - {1'b0, step_mag}) : {1'b0, step_mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COLLECT;
      avg       <= '0;
      started   <= 1'b0;
      sel_start <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // Start selection in the cycle after the final cell so that it is counted.
      sel_start <= cell_req && cells.payload.last_cell;
      if (results.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_COLLECT: begin
          if (cell_req && cells.payload.last_cell) begin
            state <= ST_SELECT;
          end
        end
        ST_SELECT: begin
          if (sel_status.done) begin
            empty_flag <= sel_status.empty;
            meas       <= {sel_status.median, 8'd0};
            if (!enable) begin
              state <= ST_CORR;
            end else if (!started) begin
              avg     <= {sel_status.median, 8'd0};
              started <= 1'b1;
              state   <= ST_CORR;
            end else begin
              state <= ST_MUL_NEW;
            end
          end
        end
        ST_MUL_NEW: begin
          prod  <= mul_out;
          state <= ST_MUL_OLD;
        end
        ST_MUL_OLD: begin
          acc   <= prod;
          prod  <= mul_out;
          state <= ST_SUM;
        end
        ST_SUM: begin
          avg   <= avg_new;
          state <= ST_CORR;
        end
        ST_CORR: begin
          // Hold the frame until the output register is free.
          if (!res_valid || results.ready) begin
            res_valid            <= 1'b1;
            res.correction       <= over_band ? corr_val : '0;
            res.drift_estimate   <= avg;
            res.apply_correction <= over_band;
            res.window_empty     <= empty_flag;
            state                <= ST_COLLECT;
          end
        end
        default: state <= ST_COLLECT;
      endcase
    end
  end

  assign results.valid   = res_valid;
  assign results.payload = res;

endmodule

`default_nettype wire

// ===== rtl/core/gdm_checker.sv =====
// Port-level checks for ground_drift_median_ema, attached by bind.
// Depends on ground_drift_median_ema_macros.svh.
`default_nettype none

`include "ground_drift_median_ema_macros.svh"

module gdm_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               cell_valid_req,
  input wire logic               cell_ready,
  input wire logic               last_cell,
  input wire logic               res_valid,
  input wire logic               res_ready,
  input wire logic signed [18:0] correction,
  input wire logic signed [23:0] drift_estimate,
  input wire logic               apply_correction
);

  `GDM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result request dropped while stalled")
  `GDM_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(correction) && $stable(drift_estimate), "result payload changed while stalled")
  `GDM_ASSERT_NEXT(a_busy_after_last, cell_valid_req && cell_ready && last_cell, !cell_ready, "cells taken while a frame end is processed")
  `GDM_ASSERT_SAME(a_no_apply_zero, res_valid && !apply_correction, correction == 19'sd0, "correction without apply flag")
  `GDM_ASSERT_SAME(a_sign_match, res_valid && apply_correction && (correction != 19'sd0), correction[18] == drift_estimate[23], "correction sign differs from average")

endmodule

bind ground_drift_median_ema gdm_checker u_gdm_checker (
  .clk              (clk),
  .rst              (rst),
  .cell_valid_req   (cells.valid),
  .cell_ready       (cells.ready),
  .last_cell        (cells.payload.last_cell),
  .res_valid        (results.valid),
  .res_ready        (results.ready),
  .correction       (results.payload.correction),
  .drift_estimate   (results.payload.drift_estimate),
  .apply_correction (results.payload.apply_correction)
);

`default_nettype wire

// ===== tb/sv/ground_drift_median_ema_checker.sv =====
// Frame scoreboard for the ground drift estimator: snoops the register port and
// both request channels, predicts every frame result and compares it field by field.
// Depends on gdm_pkg for the request structs, register indexes and widths.
module ground_drift_median_ema_checker
  import gdm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  cells_valid,
  input  logic                  cells_ready,
  input  gdm_cell_t             cell_req,
  input  logic                  results_valid,
  input  logic                  results_ready,
  input  gdm_result_t           result,
  output int                    owed,
  output int                    mismatches
);

  localparam int STORE_DEPTH = MAX_CELLS_DEF;

  // Shadow copy of the registers.
  logic       en_r;
  logic [8:0] weight_r;
  logic [9:0] band_r;
  logic [9:0] limit_r;

  // Heights kept in the current frame, plus the running average.
  logic signed [HEIGHT_W-1:0] frame_heights [STORE_DEPTH];
  int                         frame_kept;
  longint                     drift_avg;
  bit                         avg_loaded;
  gdm_result_t                owed_results [$];

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Close a frame: median of the kept heights, average update, dead band test.
  function automatic gdm_result_t close_frame();
    gdm_result_t                r;
    logic signed [HEIGHT_W-1:0] v;
    longint                     med;
    longint                     mag;
    longint                     band;
    longint                     lim;
    longint                     w;
    int                         i;
    int                         j;
    r = '0;
    r.window_empty = (frame_kept == 0);
    med = 0;
    if (frame_kept > 0) begin
      for (i = 1; i < frame_kept; i++) begin
        v = frame_heights[i];
        j = i;
        while (j > 0 && frame_heights[j-1] > v) begin
          frame_heights[j] = frame_heights[j-1];
          j--;
        end
        frame_heights[j] = v;
      end
      med = longint'(frame_heights[frame_kept/2]) * 256;
    end
    if (en_r) begin
      if (!avg_loaded) begin
        drift_avg = med;
        avg_loaded = 1'b1;
      end else begin
        w = (weight_r > WEIGHT_FULL) ? 256 : longint'(weight_r);
        drift_avg = (w * med + (256 - w) * drift_avg) >>> 8;
      end
      mag = (drift_avg < 0) ? -drift_avg : drift_avg;
      band = longint'(band_r) * 256;
      lim = longint'(limit_r) * 256;
      if (mag > band) begin
        if (mag > lim) mag = lim;
        r.correction = CORR_W'((drift_avg < 0) ? -mag : mag);
        r.apply_correction = 1'b1;
      end
    end
    r.drift_estimate = AVG_W'(drift_avg);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    gdm_result_t want;
    if (rst) begin
      en_r = ENABLE_RST;
      weight_r = EMA_WEIGHT_RST;
      band_r = DEAD_BAND_RST;
      limit_r = STEP_LIMIT_RST;
      frame_kept = 0;
      drift_avg = 0;
      avg_loaded = 1'b0;
      owed_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLE:     en_r = cfg_data[0];
          CFG_EMA_WEIGHT: weight_r = cfg_data[8:0];
          CFG_DEAD_BAND:  band_r = cfg_data[9:0];
          CFG_STEP_LIMIT: limit_r = cfg_data[9:0];
          default: ;
        endcase
      end
      if (results_valid && results_ready) begin
        if (owed_results.size() == 0) begin
          report_mismatch("result request with no frame outstanding");
        end else begin
          want = owed_results.pop_front();
          if (result.correction !== want.correction)
            report_mismatch($sformatf("correction got %0d want %0d",
                                      result.correction, want.correction));
          if (result.drift_estimate !== want.drift_estimate)
            report_mismatch($sformatf("drift_estimate got %0d want %0d",
                                      result.drift_estimate, want.drift_estimate));
          if (result.apply_correction !== want.apply_correction)
            report_mismatch($sformatf("apply_correction got %b want %b",
                                      result.apply_correction, want.apply_correction));
          if (result.window_empty !== want.window_empty)
            report_mismatch($sformatf("window_empty got %b want %b",
                                      result.window_empty, want.window_empty));
        end
      end
      if (cells_valid && cells_ready) begin
        // Keep valid, finite heights; drop them once the store is full.
        if (cell_req.cell_valid && cell_req.height_finite && frame_kept < STORE_DEPTH) begin
          frame_heights[frame_kept] = cell_req.cell_height;
          frame_kept++;
        end
        if (cell_req.last_cell) begin
          // Append at the tail so results come back in frame order.
          owed_results.insert(owed_results.size(), close_frame());
          frame_kept = 0;
        end
      end
    end
    owed <= owed_results.size();
  end

endmodule

// ===== tb/sv/ground_drift_median_ema_tb.sv =====
// Top of the ground drift estimator bench: clock, reset, cell and register stimulus.
// Depends on gdm_pkg, gdm_stream_if, ground_drift_median_ema and its frame checker.
module ground_drift_median_ema_tb;
  import gdm_pkg::*;

  // Random part stops once this many cells have been sent in the phases.
  localparam int     ITEM_GOAL     = 1100;
  localparam int     PHASES        = 10;
  // Cycles to idle after the last result before a register write or the verdict.
  localparam int     SETTLE_CYCLES = 40;
  // Time limit, set well above the worst correct run.
  localparam longint TIMEOUT_UNITS = 30_000_000;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] en;
    logic [CFG_DATA_W-1:0] weight;
    logic [CFG_DATA_W-1:0] band;
    logic [CFG_DATA_W-1:0] limit;
  } reg_set_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    owed;
  int                    mismatches;
  int                    sent_cells;
  // When set, both sides run without gaps.
  bit                    quiet;

  gdm_stream_if #(.payload_t(gdm_cell_t))   cells_if ();
  gdm_stream_if #(.payload_t(gdm_result_t)) results_if ();

  ground_drift_median_ema uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cells     (cells_if),
    .results   (results_if)
  );

  // The checker only listens; the top never looks at results itself.
  ground_drift_median_ema_checker frame_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cells_valid   (cells_if.valid),
    .cells_ready   (cells_if.ready),
    .cell_req      (cells_if.payload),
    .results_valid (results_if.valid),
    .results_ready (results_if.ready),
    .result        (results_if.payload),
    .owed          (owed),
    .mismatches    (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT_UNITS);
    $display("status: fail");
    $finish;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one cell request and hold it until the block takes it. Valid stays
  // high across back-to-back requests so it never gets two updates in one step.
  task automatic push_cell(input logic signed [HEIGHT_W-1:0] height, input bit valid,
                           input bit finite, input bit last);
    gdm_cell_t c;
    int        gap;
    c.cell_height   = height;
    c.cell_valid    = valid;
    c.height_finite = finite;
    c.last_cell     = last;
    gap = pick_gap();
    if (gap > 0) begin
      cells_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cells_if.valid   <= 1'b1;
    cells_if.payload <= c;
    @(posedge clk);
    while (!cells_if.ready) @(posedge clk);
    sent_cells++;
  endtask

  // Drop valid and wait until every frame result has come back. The first edge
  // lets the checker register a frame closed at the previous edge.
  task automatic wait_drained();
    cells_if.valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back; only call with the block idle.
  task automatic apply_regs(input reg_set_t s);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ENABLE;
    cfg_data  <= s.en;
    @(posedge clk);
    cfg_index <= CFG_EMA_WEIGHT;
    cfg_data  <= s.weight;
    @(posedge clk);
    cfg_index <= CFG_DEAD_BAND;
    cfg_data  <= s.band;
    @(posedge clk);
    cfg_index <= CFG_STEP_LIMIT;
    cfg_data  <= s.limit;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: ready in runs of random length, broken by random stalls.
  initial begin : drain_results
    int run;
    int gap;
    forever begin
      run = quiet ? 1 : $urandom_range(1, 20);
      results_if.ready <= 1'b1;
      repeat (run) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        results_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    reg_set_t                   regs;
    logic signed [HEIGHT_W-1:0] height;
    bit                         valid;
    bit                         finite;
    bit                         drop_all;
    int                         i;
    int                         r;
    int                         len;
    int                         phase;
    int                         phase_start;
    int                         level;
    int                         center;
    int                         spread;

    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= CFG_ENABLE;
    cfg_data         <= '0;
    cells_if.valid   <= 1'b0;
    cells_if.payload <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under the reset register values.
    // First frame loads the average as is; top height far outside the dead band.
    push_cell(16'sh7FFF, 1'b1, 1'b1, 1'b1);
    // Bottom height twice: median of three picks the middle rank.
    push_cell(16'sh8000, 1'b1, 1'b1, 1'b0);
    push_cell(16'sh8000, 1'b1, 1'b1, 1'b0);
    push_cell(16'sd100,  1'b1, 1'b1, 1'b1);
    // Empty windows: a lone invalid last cell, then non-finite and dropped cells.
    push_cell(16'sd1234, 1'b0, 1'b1, 1'b1);
    push_cell(16'sd77,   1'b1, 1'b0, 1'b0);
    push_cell(-16'sd77,  1'b0, 1'b0, 1'b1);
    // Ignored last cell still closes a frame with two kept heights.
    push_cell(16'sd5,    1'b1, 1'b1, 1'b0);
    push_cell(-16'sd7,   1'b1, 1'b1, 1'b0);
    push_cell(16'sd999,  1'b1, 1'b0, 1'b1);
    // Even count: rank n/2 is the upper of the two middle heights.
    push_cell(16'sd10,   1'b1, 1'b1, 1'b0);
    push_cell(-16'sd20,  1'b1, 1'b1, 1'b0);
    push_cell(16'sd30,   1'b1, 1'b1, 1'b0);
    push_cell(-16'sd40,  1'b1, 1'b1, 1'b1);
    // All equal, zero median.
    push_cell(16'sd0,    1'b1, 1'b1, 1'b0);
    push_cell(16'sd0,    1'b1, 1'b1, 1'b0);
    push_cell(16'sd0,    1'b1, 1'b1, 1'b1);
    wait_drained();

    // Store full: fill the store with random heights, then offer extra top
    // heights that must be dropped; counting them would move the median.
    quiet = 1'b1;
    for (i = 0; i < MAX_CELLS_DEF; i++)
      push_cell(HEIGHT_W'($urandom), 1'b1, 1'b1, 1'b0);
    for (i = 0; i < 7; i++)
      push_cell(16'sh7FFF, 1'b1, 1'b1, i == 6);
    wait_drained();

    // Random phases, one register setting each. Extremes come first; the last
    // phases use raw 10-bit values, high bits included.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       regs = '{10'd1,    10'd0,    10'd0,    10'd1000};
        1:       regs = '{10'd1,    10'd256,  10'd0,    10'd0};
        2:       regs = '{10'd0,    10'd128,  10'd50,   10'd5};
        3:       regs = '{10'd1,    10'd300,  10'd1000, 10'd1023};
        4:       regs = '{10'd1,    10'h3FF,  10'd1023, 10'd0};
        5:       regs = '{10'h3FF,  10'd1,    10'd10,   10'd20};
        6:       regs = '{10'd1,    10'd26,   10'd3,    10'd1000};
        7:       regs = '{10'd1,    10'd64,   10'd0,    10'd1023};
        default: regs = '{CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                          CFG_DATA_W'($urandom), CFG_DATA_W'($urandom)};
      endcase
      apply_regs(regs);
      quiet = (phase % 4 == 3);
      // Drift level for this phase, in mm, spanning the whole dead band range.
      level = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 1100));
      phase_start = sent_cells;
      while (sent_cells - phase_start < ITEM_GOAL / PHASES) begin
        r = $urandom_range(0, 99);
        if (r < 70)      len = $urandom_range(1, 8);
        else if (r < 95) len = $urandom_range(9, 40);
        else             len = $urandom_range(41, 120);
        center   = level + int'($urandom_range(0, 40)) - 20;
        spread   = $urandom_range(0, 60);
        drop_all = ($urandom_range(0, 19) == 0);
        for (i = 0; i < len; i++) begin
          r = $urandom_range(0, 99);
          valid  = !(drop_all || r < 8 || (r >= 14 && r < 17));
          finite = !(r >= 8 && r < 17);
          r = $urandom_range(0, 99);
          if (r < 5)       height = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
          else if (r < 15) height = HEIGHT_W'($urandom);
          else             height = HEIGHT_W'(center + int'($urandom_range(0, 2 * spread))
                                              - spread);
          push_cell(height, valid, finite, i == len - 1);
        end
      end
      wait_drained();
    end

    if (mismatches == 0 && owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/gdm_pkg.sv
rtl/core/gdm_stream_if.sv
rtl/core/gdm_select.sv
rtl/core/ground_drift_median_ema.sv
rtl/core/gdm_checker.sv
tb/sv/ground_drift_median_ema_checker.sv
tb/sv/ground_drift_median_ema_tb.sv
